// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the page packer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define LCDPP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition holds in the cycle after a trigger.
`define LCDPP_ASSERT_NEXT(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) else $error(msg);

`endif

// ===== hdl/lcdpp_pkg.sv =====
// Shared types, codes and defaults for the monochrome LCD page packer.
package lcdpp_pkg;

  // Geometry defaults
  localparam int DEF_PAGES            = 4;
  localparam int DEF_COLUMNS_PER_SIDE = 61;
  localparam int PAGE_ROWS            = 8;
  localparam int BYTE_W               = 8;
  localparam int PLANE_SEL_W          = 3;
  localparam int SIDE_W               = 2;
  localparam int CFG_INDEX_W          = 3;
  localparam int OUT_USER_W           = 3;

  // Command and register reset values
  localparam logic [BYTE_W-1:0] COLUMN_OFFSET = 8'h13;
  localparam logic [BYTE_W-1:0] RST_THRESHOLD = 8'd0;
  localparam logic [BYTE_W-1:0] RST_PAGE_CMD  = 8'd184;
  localparam logic [BYTE_W-1:0] RST_COL_CMD   = 8'd0;
  localparam logic [BYTE_W-1:0] RST_RMW_START = 8'd224;
  localparam logic [BYTE_W-1:0] RST_RMW_END   = 8'd238;

  // Strobe selection codes
  localparam logic [SIDE_W-1:0] SIDE_LEFT  = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_BOTH  = 2'd3;

  // Input word kinds
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD = 3'd0,
    REG_PAGE_CMD  = 3'd1,
    REG_COL_CMD   = 3'd2,
    REG_RMW_START = 3'd3,
    REG_RMW_END   = 3'd4
  } cfg_reg_t;

  typedef enum logic [2:0] {
    STEP_PAGE,
    STEP_COLUMN,
    STEP_RMW_START,
    STEP_DATA,
    STEP_RMW_END
  } step_kind_t;

  // What one fetch word produces, minus the store data
  typedef struct packed {
    step_kind_t        kind;
    logic [SIDE_W-1:0] side;
    logic              last;
  } step_info_t;

  // Bit-plane store write request
  typedef struct packed {
    logic                   en;
    logic                   all_planes;
    logic [PLANE_SEL_W-1:0] plane;
    logic                   value;
  } store_wr_t;

endpackage

// ===== hdl/lcdpp_store.sv =====
// Page store: eight one-bit planes, one write and one registered read per cycle.
module lcdpp_store #(
  parameter int DEPTH  = lcdpp_pkg::DEF_PAGES * 2 * lcdpp_pkg::DEF_COLUMNS_PER_SIDE,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic                            clk,
  input  lcdpp_pkg::store_wr_t            wr,
  input  logic [ADDR_W-1:0]               wr_addr,
  input  logic                            rd_en,
  input  logic [ADDR_W-1:0]               rd_addr,
  output logic [lcdpp_pkg::BYTE_W-1:0]    rd_data
);
  import lcdpp_pkg::*;

  // One plane per row within a page; a load touches one plane only
  for (genvar b = 0; b < PAGE_ROWS; b++) begin : g_plane
    logic plane_mem [DEPTH];
    logic rd_bit_r;

    always_ff @(posedge clk) begin
      if (wr.en && (wr.all_planes || (wr.plane == PLANE_SEL_W'(b)))) begin
        plane_mem[wr_addr] <= wr.value;
      end
      if (rd_en) begin
        rd_bit_r <= plane_mem[rd_addr];
      end
    end

    assign rd_data[b] = rd_bit_r;
  end

endmodule

// ===== hdl/lcdpp_load_ctrl.sv =====
// Load side: raster position counters, thresholding and the post-reset clear sweep.
module lcdpp_load_ctrl #(
  parameter int COLUMN_COUNT = 2 * lcdpp_pkg::DEF_COLUMNS_PER_SIDE,
  parameter int DEPTH        = lcdpp_pkg::DEF_PAGES * COLUMN_COUNT,
  parameter int ADDR_W       = $clog2(DEPTH)
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           load_en,
  input  logic [lcdpp_pkg::BYTE_W-1:0]   pixel_value,
  input  logic [lcdpp_pkg::BYTE_W-1:0]   threshold,
  output logic                           busy,
  output lcdpp_pkg::store_wr_t           wr,
  output logic [ADDR_W-1:0]              wr_addr
);
  import lcdpp_pkg::*;

  localparam int                COL_W     = $clog2(COLUMN_COUNT);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(COLUMN_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'(DEPTH - COLUMN_COUNT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [ADDR_W-1:0] BASE_STEP = ADDR_W'(COLUMN_COUNT);

  logic                   clr_busy_r, clr_busy_nxt;
  logic [ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [COL_W-1:0]       col_r, col_nxt;
  logic [PLANE_SEL_W-1:0] row_bit_r, row_bit_nxt;
  logic [ADDR_W-1:0]      base_r, base_nxt;

  // Drive the store: zero sweep first, then thresholded pixels
  always_comb begin
    if (clr_busy_r) begin
      wr.en         = 1'b1;
      wr.all_planes = 1'b1;
      wr.plane      = '0;
      wr.value      = 1'b0;
      wr_addr       = clr_addr_r;
    end else begin
      wr.en         = load_en;
      wr.all_planes = 1'b0;
      wr.plane      = row_bit_r;
      wr.value      = (pixel_value > threshold);
      wr_addr       = base_r + ADDR_W'(col_r);
    end
  end

  // Advance the clear sweep and the raster position
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    col_nxt      = col_r;
    row_bit_nxt  = row_bit_r;
    base_nxt     = base_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + ADDR_W'(1);
      if (clr_addr_r == LAST_ADDR) begin
        clr_busy_nxt = 1'b0;
      end
    end else if (load_en) begin
      if (col_r == LAST_COL) begin
        col_nxt     = '0;
        row_bit_nxt = row_bit_r + PLANE_SEL_W'(1);
        if (row_bit_r == PLANE_SEL_W'(PAGE_ROWS - 1)) begin
          base_nxt = (base_r == LAST_BASE) ? '0 : base_r + BASE_STEP;
        end
      end else begin
        col_nxt = col_r + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
      col_r      <= '0;
      row_bit_r  <= '0;
      base_r     <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
      col_r      <= col_nxt;
      row_bit_r  <= row_bit_nxt;
      base_r     <= base_nxt;
    end
  end

  assign busy = clr_busy_r;

endmodule

// ===== hdl/lcdpp_fetch_seq.sv =====
// Fetch side: walks the per-page command and data sequence and forms the read address.
module lcdpp_fetch_seq #(
  parameter int PAGES            = lcdpp_pkg::DEF_PAGES,
  parameter int COLUMNS_PER_SIDE = lcdpp_pkg::DEF_COLUMNS_PER_SIDE,
  parameter int DEPTH            = PAGES * 2 * COLUMNS_PER_SIDE,
  parameter int ADDR_W           = $clog2(DEPTH),
  parameter int PAGE_W           = (PAGES > 1) ? $clog2(PAGES) : 1
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step_en,
  output lcdpp_pkg::step_info_t  info,
  output logic [PAGE_W-1:0]      page,
  output logic [ADDR_W-1:0]      rd_addr
);
  import lcdpp_pkg::*;

  localparam int                COLUMN_COUNT = 2 * COLUMNS_PER_SIDE;
  localparam int                PAGE_STEPS   = COLUMN_COUNT + 4;
  localparam int                OFF_W        = $clog2(PAGE_STEPS);
  localparam int                CPS_W        = (COLUMNS_PER_SIDE > 1) ?
                                               $clog2(COLUMNS_PER_SIDE) : 1;
  localparam logic [OFF_W-1:0]  LAST_OFF     = OFF_W'(PAGE_STEPS - 1);
  localparam logic [PAGE_W-1:0] LAST_PAGE    = PAGE_W'(PAGES - 1);
  localparam logic [ADDR_W-1:0] BASE_STEP    = ADDR_W'(COLUMN_COUNT);
  localparam logic [ADDR_W-1:0] RIGHT_OFS    = ADDR_W'(COLUMNS_PER_SIDE);

  logic [OFF_W-1:0]  off_r, off_nxt;
  logic [CPS_W-1:0]  col_r, col_nxt;
  logic              side_r, side_nxt;
  logic [PAGE_W-1:0] page_r, page_nxt;
  logic [ADDR_W-1:0] base_r, base_nxt;

  // Decode the position within the page
  always_comb begin
    if (off_r == OFF_W'(0)) begin
      info.kind = STEP_PAGE;
    end else if (off_r == OFF_W'(1)) begin
      info.kind = STEP_COLUMN;
    end else if (off_r == OFF_W'(2)) begin
      info.kind = STEP_RMW_START;
    end else if (off_r == LAST_OFF) begin
      info.kind = STEP_RMW_END;
    end else begin
      info.kind = STEP_DATA;
    end
    if (info.kind == STEP_DATA) begin
      info.side = side_r ? SIDE_RIGHT : SIDE_LEFT;
    end else begin
      info.side = SIDE_BOTH;
    end
    info.last = (page_r == LAST_PAGE) && (off_r == LAST_OFF);
  end

  // Right-half bytes sit one half-row further into the page
  assign rd_addr = base_r + ADDR_W'(col_r) + (side_r ? RIGHT_OFS : '0);
  assign page    = page_r;

  // Step to the next word of the frame
  always_comb begin
    off_nxt  = off_r;
    col_nxt  = col_r;
    side_nxt = side_r;
    page_nxt = page_r;
    base_nxt = base_r;
    if (step_en) begin
      if (off_r == LAST_OFF) begin
        off_nxt  = '0;
        col_nxt  = '0;
        side_nxt = 1'b0;
        if (page_r == LAST_PAGE) begin
          page_nxt = '0;
          base_nxt = '0;
        end else begin
          page_nxt = page_r + PAGE_W'(1);
          base_nxt = base_r + BASE_STEP;
        end
      end else begin
        off_nxt = off_r + OFF_W'(1);
        if (info.kind == STEP_DATA) begin
          side_nxt = !side_r;
          if (side_r) begin
            col_nxt = col_r + CPS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r  <= '0;
      col_r  <= '0;
      side_r <= 1'b0;
      page_r <= '0;
      base_r <= '0;
    end else begin
      off_r  <= off_nxt;
      col_r  <= col_nxt;
      side_r <= side_nxt;
      page_r <= page_nxt;
      base_r <= base_nxt;
    end
  end

endmodule

// ===== hdl/mono_lcd_page_packer.sv =====
// Top level of the monochrome LCD page packer: handshakes, registers and result stage.
//
// Load words (tuser 0) carry one gray pixel in raster order, PAGES*8 rows of
// 2*COLUMNS_PER_SIDE columns; each is thresholded into one bit of a page-packed
// byte store and produces no output. Fetch words (tuser 1) each return the next
// byte of the frame write sequence: per page a set-page, set-column and
// read-modify-write start command to both halves, then left/right data byte
// pairs, then the end command; tlast marks the frame's final byte. One word is
// taken every cycle unless the result stage stalls, loads and fetches mixed freely;
// a fetch result passes through the store read register, then the output register.
// After reset the store is swept to zero, one address per cycle, over all
// PAGES*2*COLUMNS_PER_SIDE addresses (488 by default) with in_tready low;
// configuration writes are taken throughout and should be made while idle.
`include "assert_macros.svh"

module mono_lcd_page_packer #(
  parameter int PAGES            = lcdpp_pkg::DEF_PAGES,
  parameter int COLUMNS_PER_SIDE = lcdpp_pkg::DEF_COLUMNS_PER_SIDE
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // Input words
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [lcdpp_pkg::BYTE_W-1:0]        in_tdata,   // [7:0] pixel_value
  input  logic                                in_tuser,   // [0] mode
  // Result words
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [lcdpp_pkg::BYTE_W-1:0]        out_tdata,  // [7:0] bus_byte
  output logic [lcdpp_pkg::OUT_USER_W-1:0]    out_tuser,  // [0] is_data, [2:1] strobe_side
  output logic                                out_tlast,  // frame_last
  // Register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lcdpp_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [lcdpp_pkg::BYTE_W-1:0]        cfg_data
);
  import lcdpp_pkg::*;

  localparam int COLUMN_COUNT = 2 * COLUMNS_PER_SIDE;
  localparam int DEPTH        = PAGES * COLUMN_COUNT;
  localparam int ADDR_W       = $clog2(DEPTH);
  localparam int PAGE_W       = (PAGES > 1) ? $clog2(PAGES) : 1;

  // Configuration registers
  logic [BYTE_W-1:0] threshold_r, page_cmd_r, col_cmd_r, rmw_start_r, rmw_end_r;

  // Pipeline control
  logic in_accept, load_accept, fetch_accept, out_load, clr_busy;

  // Store connections
  store_wr_t         st_wr;
  logic [ADDR_W-1:0] st_wr_addr;
  logic [ADDR_W-1:0] st_rd_addr;
  logic [BYTE_W-1:0] st_rd_data;

  // Sequencer outputs
  step_info_t        seq_info;
  logic [PAGE_W-1:0] seq_page;

  // Read stage and result stage
  logic              s1_vld_r, s1_vld_nxt;
  step_info_t        s1_info_r;
  logic [PAGE_W-1:0] s1_page_r;
  logic              out_vld_r;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic [OUT_USER_W-1:0] out_user_r;
  logic              out_last_r;

  assign out_load     = !out_vld_r || out_tready;
  assign in_tready    = !clr_busy && (!s1_vld_r || out_load);
  assign in_accept    = in_tvalid && in_tready;
  assign load_accept  = in_accept && (in_tuser == MODE_LOAD);
  assign fetch_accept = in_accept && (in_tuser == MODE_FETCH);
  assign cfg_ready    = 1'b1;

  // Take register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= RST_THRESHOLD;
      page_cmd_r  <= RST_PAGE_CMD;
      col_cmd_r   <= RST_COL_CMD;
      rmw_start_r <= RST_RMW_START;
      rmw_end_r   <= RST_RMW_END;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_THRESHOLD: threshold_r <= cfg_data;
        REG_PAGE_CMD:  page_cmd_r  <= cfg_data;
        REG_COL_CMD:   col_cmd_r   <= cfg_data;
        REG_RMW_START: rmw_start_r <= cfg_data;
        REG_RMW_END:   rmw_end_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  lcdpp_load_ctrl #(
    .COLUMN_COUNT (COLUMN_COUNT),
    .DEPTH        (DEPTH),
    .ADDR_W       (ADDR_W)
  ) u_load (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_en     (load_accept),
    .pixel_value (in_tdata),
    .threshold   (threshold_r),
    .busy        (clr_busy),
    .wr          (st_wr),
    .wr_addr     (st_wr_addr)
  );

  lcdpp_fetch_seq #(
    .PAGES            (PAGES),
    .COLUMNS_PER_SIDE (COLUMNS_PER_SIDE),
    .DEPTH            (DEPTH),
    .ADDR_W           (ADDR_W),
    .PAGE_W           (PAGE_W)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (fetch_accept),
    .info    (seq_info),
    .page    (seq_page),
    .rd_addr (st_rd_addr)
  );

  lcdpp_store #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_store (
    .clk     (clk),
    .wr      (st_wr),
    .wr_addr (st_wr_addr),
    .rd_en   (fetch_accept),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // Read stage: hold the step while the store read completes
  always_comb begin
    if (fetch_accept) begin
      s1_vld_nxt = 1'b1;
    end else if (out_load) begin
      s1_vld_nxt = 1'b0;
    end else begin
      s1_vld_nxt = s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= s1_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_accept) begin
      s1_info_r <= seq_info;
      s1_page_r <= seq_page;
    end
  end

  // Pick the bus byte for the step
  always_comb begin
    case (s1_info_r.kind)
      STEP_PAGE:      out_byte_nxt = page_cmd_r | BYTE_W'(s1_page_r);
      STEP_COLUMN:    out_byte_nxt = col_cmd_r | COLUMN_OFFSET;
      STEP_RMW_START: out_byte_nxt = rmw_start_r;
      STEP_RMW_END:   out_byte_nxt = rmw_end_r;
      STEP_DATA:      out_byte_nxt = st_rd_data;
      default:        out_byte_nxt = st_rd_data;
    endcase
  end

  // Result stage: load when empty or drained
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_vld_r) begin
      out_byte_r <= out_byte_nxt;
      out_user_r <= {s1_info_r.side, (s1_info_r.kind == STEP_DATA)};
      out_last_r <= s1_info_r.last;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_byte_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

  // No word is taken while the store is being cleared
  `LCDPP_ASSERT(a_no_accept_in_clear, !(clr_busy && in_tready), "word accepted during clear")
  // A load never creates a pending result
  `LCDPP_ASSERT_NEXT(a_load_no_result, load_accept && !s1_vld_r, !s1_vld_r, "load made a result")
  // The frame's last byte is the end command to both halves
  `LCDPP_ASSERT(a_last_is_end, !(out_tvalid && out_tlast) || (!out_tuser[0] && (out_tuser[2:1] == SIDE_BOTH)), "bad last word")
  // Display data goes to exactly one half
  `LCDPP_ASSERT(a_data_one_side, !(out_tvalid && out_tuser[0]) || (out_tuser[2:1] == SIDE_LEFT) || (out_tuser[2:1] == SIDE_RIGHT), "data to both halves")

endmodule

// ===== bench/tb_mono_lcd_page_packer.sv =====
// Self-checking testbench for the monochrome LCD page packer: stream stimulus and scoreboard.
module tb_mono_lcd_page_packer;
  import lcdpp_pkg::*;

  // Frame geometry
  localparam int ROW_BYTES   = 2 * DEF_COLUMNS_PER_SIDE;
  localparam int ROWS        = DEF_PAGES * PAGE_ROWS;
  localparam int STORE_BYTES = DEF_PAGES * ROW_BYTES;
  localparam int PAGE_STEPS  = ROW_BYTES + 4;
  localparam int FRAME_STEPS = DEF_PAGES * PAGE_STEPS;
  // Clear sweep plus about 760 words, each with the longest sender gap and receiver stall
  localparam int CYCLE_LIMIT = 2_000_000;

  // One bus write as the LCD sees it
  typedef struct packed {
    logic [BYTE_W-1:0] bus_byte;
    logic              is_data;
    logic [SIDE_W-1:0] side;
    logic              last;
  } bus_word_t;

  // Mirror of the page store and both sequencers, plus the queue of pending bus words
  class lcd_sequence_board;
    logic [BYTE_W-1:0] store_bytes [STORE_BYTES];
    int unsigned       load_row;
    int unsigned       load_col;
    int unsigned       fetch_pos;
    logic [BYTE_W-1:0] threshold, page_base, col_base, rmw_start, rmw_end;
    bus_word_t         expected_words [$];
    int                mismatches, loads, fetches, frames;

    function new();
      foreach (store_bytes[i]) store_bytes[i] = '0;
      load_row   = 0;
      load_col   = 0;
      fetch_pos  = 0;
      threshold  = RST_THRESHOLD;
      page_base  = RST_PAGE_CMD;
      col_base   = RST_COL_CMD;
      rmw_start  = RST_RMW_START;
      rmw_end    = RST_RMW_END;
      mismatches = 0;
      loads      = 0;
      fetches    = 0;
      frames     = 0;
    endfunction

    function void set_reg(cfg_reg_t idx, logic [BYTE_W-1:0] value);
      case (idx)
        REG_THRESHOLD: threshold = value;
        REG_PAGE_CMD:  page_base = value;
        REG_COL_CMD:   col_base  = value;
        REG_RMW_START: rmw_start = value;
        REG_RMW_END:   rmw_end   = value;
        default: ;
      endcase
    endfunction

    // Threshold one pixel into its page byte and step the raster position
    function void load_pixel(logic [BYTE_W-1:0] pix);
      int unsigned addr;
      addr = (load_row / PAGE_ROWS) * ROW_BYTES + load_col;
      store_bytes[addr][load_row % PAGE_ROWS] = (pix > threshold);
      if (load_col == ROW_BYTES - 1) begin
        load_col = 0;
        load_row = (load_row == ROWS - 1) ? 0 : load_row + 1;
      end else begin
        load_col++;
      end
    endfunction

    // Work out the next byte of the frame write sequence
    function bus_word_t next_bus_word();
      bus_word_t   w;
      step_kind_t  kind;
      int unsigned page, offset, k, col;
      page   = fetch_pos / PAGE_STEPS;
      offset = fetch_pos % PAGE_STEPS;
      if (offset == 0) kind = STEP_PAGE;
      else if (offset == 1) kind = STEP_COLUMN;
      else if (offset == 2) kind = STEP_RMW_START;
      else if (offset == PAGE_STEPS - 1) kind = STEP_RMW_END;
      else kind = STEP_DATA;
      w.is_data = 1'b0;
      w.side    = SIDE_BOTH;
      case (kind)
        STEP_PAGE:      w.bus_byte = page_base | BYTE_W'(page);
        STEP_COLUMN:    w.bus_byte = col_base | COLUMN_OFFSET;
        STEP_RMW_START: w.bus_byte = rmw_start;
        STEP_RMW_END:   w.bus_byte = rmw_end;
        default: begin
          // Left half first, then the matching right-half column
          k   = offset - 3;
          col = k / 2;
          if (k % 2 == 1) begin
            col    = col + DEF_COLUMNS_PER_SIDE;
            w.side = SIDE_RIGHT;
          end else begin
            w.side = SIDE_LEFT;
          end
          w.bus_byte = store_bytes[page * ROW_BYTES + col];
          w.is_data  = 1'b1;
        end
      endcase
      w.last = (fetch_pos == FRAME_STEPS - 1);
      if (w.last) frames++;
      fetch_pos = (fetch_pos == FRAME_STEPS - 1) ? 0 : fetch_pos + 1;
      return w;
    endfunction

    function void note_word(logic mode, logic [BYTE_W-1:0] pix);
      if (mode == MODE_LOAD) begin
        loads++;
        load_pixel(pix);
      end else begin
        fetches++;
        expected_words.push_back(next_bus_word());
      end
    endfunction

    task report(string msg);
      $display("MISMATCH at %0t: %s", $time, msg);
      mismatches++;
    endtask

    task check_word(logic [BYTE_W-1:0] got_byte, logic [OUT_USER_W-1:0] got_user,
                    logic got_last);
      bus_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("result word %02h with no fetch pending", got_byte));
        return;
      end
      want = expected_words.pop_front();
      if (got_byte !== want.bus_byte)
        report($sformatf("bus_byte %02h, want %02h", got_byte, want.bus_byte));
      if (got_user[0] !== want.is_data)
        report($sformatf("is_data %b, want %b", got_user[0], want.is_data));
      if (got_user[2:1] !== want.side)
        report($sformatf("strobe_side %0d, want %0d", got_user[2:1], want.side));
      if (got_last !== want.last)
        report($sformatf("frame_last %b, want %b", got_last, want.last));
    endtask
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata;    // [7:0] pixel_value
  logic                  in_tuser;    // [0] mode
  logic                  out_tvalid;
  logic                  out_tready;
  logic [BYTE_W-1:0]     out_tdata;   // [7:0] bus_byte
  logic [OUT_USER_W-1:0] out_tuser;   // [0] is_data, [2:1] strobe_side
  logic                  out_tlast;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_reg_t              cfg_index;
  logic [BYTE_W-1:0]     cfg_data;

  lcd_sequence_board board = new();
  int                cycle_count = 0;
  int                burst_left  = 0;

  mono_lcd_page_packer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // Abort a hung run
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycle_count);
    $display("end of test: mismatches");
    $finish;
  end

  // Sample both handshakes on the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_word(in_tuser, in_tdata);
      if (out_tvalid && out_tready) board.check_word(out_tdata, out_tuser, out_tlast);
    end
  end

  // Receiver back-pressure: ready stretches mostly short, some long; short stalls, a few long ones
  initial begin
    int hi, lo, r;
    out_tready = 1'b0;
    forever begin
      r  = $urandom_range(0, 99);
      hi = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      r  = $urandom_range(0, 99);
      lo = (r < 85) ? $urandom_range(0, 2) : (r < 97) ? $urandom_range(3, 6)
                                                       : $urandom_range(20, 50);
      repeat (hi) @(negedge clk) out_tready = 1'b1;
      repeat (lo) @(negedge clk) out_tready = 1'b0;
    end
  end

  // Sender gap: mostly none, some short, a few long, with gap-free bursts
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Gray value biased toward the extremes and the threshold edge
  function automatic logic [BYTE_W-1:0] pick_pixel();
    case ($urandom_range(0, 9))
      0:       return 8'd0;
      1:       return 8'd255;
      2:       return board.threshold;
      3:       return board.threshold + 8'd1;
      default: return BYTE_W'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic send_word(logic mode, logic [BYTE_W-1:0] pix);
    int gap;
    gap = pick_gap();
    repeat (gap) @(negedge clk) in_tvalid = 1'b0;
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser  = mode;
    in_tdata  = pix;
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold off until every fetch has come back
  task automatic wait_results();
    @(negedge clk) in_tvalid = 1'b0;
    while (board.expected_words.size() != 0) @(negedge clk);
  endtask

  // Drain, then let the pipeline settle before touching registers
  task automatic drain();
    wait_results();
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_reg_t idx, logic [BYTE_W-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    board.set_reg(idx, value);
    @(negedge clk) cfg_valid = 1'b0;
  endtask

  task automatic program_regs(logic [BYTE_W-1:0] thr, logic [BYTE_W-1:0] pg,
                              logic [BYTE_W-1:0] col, logic [BYTE_W-1:0] rs,
                              logic [BYTE_W-1:0] re);
    cfg_write(REG_THRESHOLD, thr);
    cfg_write(REG_PAGE_CMD, pg);
    cfg_write(REG_COL_CMD, col);
    cfg_write(REG_RMW_START, rs);
    cfg_write(REG_RMW_END, re);
  endtask

  task automatic program_random();
    program_regs(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)),
                 BYTE_W'($urandom_range(0, 255)));
  endtask

  // Random loads and fetches, with an occasional pause for all results
  task automatic random_mix(int count, int fetch_pct);
    logic mode;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 49) == 0) wait_results();
      mode = ($urandom_range(0, 99) < fetch_pct) ? MODE_FETCH : MODE_LOAD;
      send_word(mode, pick_pixel());
    end
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tuser  = MODE_LOAD;
    in_tdata  = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // Reset registers: commands before any load, then data after three loads into a cleared store
    send_word(MODE_FETCH, 8'h00);
    send_word(MODE_FETCH, 8'hFF);
    send_word(MODE_FETCH, 8'h5A);
    send_word(MODE_LOAD, 8'd0);
    send_word(MODE_LOAD, 8'd255);
    send_word(MODE_LOAD, 8'd1);
    send_word(MODE_FETCH, 8'hA5);
    send_word(MODE_FETCH, 8'h00);
    send_word(MODE_FETCH, 8'hFF);
    send_word(MODE_FETCH, 8'h0F);
    drain();

    // All registers at max: no pixel can light, command ORs saturate
    program_regs(8'd255, 8'd255, 8'd255, 8'd255, 8'd255);
    send_word(MODE_LOAD, 8'd255);
    send_word(MODE_LOAD, 8'd0);
    send_word(MODE_FETCH, 8'hFF);
    send_word(MODE_FETCH, 8'h00);
    random_mix(100, 50);
    drain();

    // All registers at zero
    program_regs(8'd0, 8'd0, 8'd0, 8'd0, 8'd0);
    random_mix(100, 50);
    drain();

    // Whole frame of fetches, running past the sequence wrap
    program_random();
    for (int i = 0; i < FRAME_STEPS + 6; i++)
      send_word(MODE_FETCH, BYTE_W'($urandom_range(0, 255)));
    drain();

    // Random registers, fetch-light mix
    program_random();
    random_mix(40, 40);

    wait_results();
    repeat (6) @(posedge clk);
    $display("covered %0d pixel loads and %0d byte fetches, %0d complete frame sequences",
             board.loads, board.fetches, board.frames);
    $display("register settings: reset, all 255, all 0 and two random sets");
    if (board.mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", board.mismatches);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
